// ===== rtl/crlf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_pkg: shared types and constants of the CR LF line receiver
// Buffer geometry, character codes, item kinds and the status and write
// request structs that pass between the control logic and the top level.
// ----------------------------------------------------------------------------
package crlf_pkg;

  // Line buffer geometry.
  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Field widths of the stream items.
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 8;
  localparam int LENGTH_W  = 9;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;

  // Item kinds carried in the input tuser.
  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Line status after an item has been applied.
  typedef struct packed {
    logic             line_done;
    logic             cr_seen;
    logic [CNT_W-1:0] char_count;
  } line_status_t;

  // Write request into the line buffer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

endpackage

// ===== rtl/crlf_line_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_receiver_top: CR LF terminated line receiver
// Assembles received bytes into a line buffer and answers status and buffer
// reads, one result per input item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and gives its result in the next
// cycle from an output register; the input is ready whenever that register
// is empty or is being emptied, so a stalled result stalls the input. The
// line buffer is a single memory with one write port, used for each stored
// character in the cycle its item is accepted, and one registered read port,
// used for buffer reads; a write is complete before any later item reads, so
// reads always see earlier characters. The buffer is not cleared after reset:
// an entry that was never written reads back an arbitrary value.
// ----------------------------------------------------------------------------
module crlf_line_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] read_index
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] line_ready, [1] cr_pending,
                                  // [10:2] line_length, [18:11] entry_data,
                                  // [23:19] zero
);

  logic                          in_acc;
  crlf_pkg::mode_t               in_mode;
  logic [crlf_pkg::BYTE_W-1:0]   in_rx_byte;
  logic [crlf_pkg::INDEX_W-1:0]  in_read_index;
  logic                          read_in_range;
  crlf_pkg::line_status_t        status_nxt;
  crlf_pkg::buf_wr_t             buf_wr;

  logic                          res_valid_r;
  crlf_pkg::line_status_t        res_status_r;
  logic                          res_read_r;
  logic [crlf_pkg::BYTE_W-1:0]   rd_data_r;
  logic [crlf_pkg::BYTE_W-1:0]   entry_data;

  logic [crlf_pkg::BYTE_W-1:0]   line_mem [crlf_pkg::BUF_DEPTH];

  // Input unpacking and handshake.
  assign in_mode       = crlf_pkg::mode_t'(in_tuser);
  assign in_rx_byte    = in_tdata[7:0];
  assign in_read_index = in_tdata[15:8];
  assign in_tready     = !res_valid_r || out_tready;
  assign in_acc        = in_tvalid && in_tready;
  assign read_in_range = (32'(in_read_index) < crlf_pkg::BUF_DEPTH);

  crlf_line_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_acc   (in_acc),
    .mode       (in_mode),
    .rx_byte    (in_rx_byte),
    .status_nxt (status_nxt),
    .buf_wr     (buf_wr)
  );

  // Line buffer: write port for stored characters.
  always_ff @(posedge clk) begin
    if (buf_wr.we) begin
      line_mem[buf_wr.addr] <= buf_wr.data;
    end
  end

  // Line buffer: registered read port, held while the result waits.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[crlf_pkg::ADDR_W'(in_read_index)];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_acc) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status_r <= status_nxt;
      res_read_r   <= (in_mode == crlf_pkg::MODE_READ) && read_in_range;
    end
  end

  // Output packing.
  assign entry_data = res_read_r ? rd_data_r : '0;
  assign out_tvalid = res_valid_r;
  assign out_tdata  = {5'd0,
                       entry_data,
                       crlf_pkg::LENGTH_W'(res_status_r.char_count),
                       res_status_r.cr_seen,
                       res_status_r.line_done};

`ifndef SYNTHESIS
  // A result that is not taken stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A clear leaves an empty line in its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == crlf_pkg::MODE_CLEAR |=> out_tdata[10:0] == 11'd0)
    else $error("clear did not empty the line");

  // Only buffer reads carry data.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode != crlf_pkg::MODE_READ |=> out_tdata[18:11] == 8'd0)
    else $error("entry data on a non-read result");
`endif

endmodule

// ===== rtl/crlf_line_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_ctrl: line assembly control
// Holds the character count and the CR and line complete flags, applies each
// accepted item to them and issues the buffer write for a stored character.
// ----------------------------------------------------------------------------
module crlf_line_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_acc,
  input  crlf_pkg::mode_t                mode,
  input  logic [crlf_pkg::BYTE_W-1:0]    rx_byte,
  output crlf_pkg::line_status_t         status_nxt,
  output crlf_pkg::buf_wr_t              buf_wr
);

  logic                       line_done_r, line_done_nxt;
  logic                       cr_seen_r, cr_seen_nxt;
  logic [crlf_pkg::CNT_W-1:0] char_count_r, char_count_nxt;
  logic                       buf_full;
  logic                       store_byte;

  assign buf_full = (char_count_r >= crlf_pkg::CNT_W'(crlf_pkg::BUF_DEPTH));

  // Next line state for the item presented at the input.
  always_comb begin
    line_done_nxt  = line_done_r;
    cr_seen_nxt    = cr_seen_r;
    char_count_nxt = char_count_r;
    store_byte     = 1'b0;
    case (mode)
      crlf_pkg::MODE_BYTE: begin
        if (!line_done_r) begin
          if (cr_seen_r) begin
            // Only LF may follow a CR; anything else throws the line away.
            cr_seen_nxt = 1'b0;
            if (rx_byte == crlf_pkg::CHAR_LF) begin
              line_done_nxt = 1'b1;
            end else begin
              char_count_nxt = '0;
            end
          end else if (rx_byte == crlf_pkg::CHAR_CR) begin
            cr_seen_nxt = 1'b1;
          end else if (buf_full) begin
            char_count_nxt = '0;
          end else begin
            store_byte     = 1'b1;
            char_count_nxt = char_count_r + 1'b1;
          end
        end
      end
      crlf_pkg::MODE_CLEAR: begin
        line_done_nxt  = 1'b0;
        cr_seen_nxt    = 1'b0;
        char_count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated on each accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_done_r  <= 1'b0;
      cr_seen_r    <= 1'b0;
      char_count_r <= '0;
    end else if (item_acc) begin
      line_done_r  <= line_done_nxt;
      cr_seen_r    <= cr_seen_nxt;
      char_count_r <= char_count_nxt;
    end
  end

  // Status as seen after the item, and the buffer write it causes.
  always_comb begin
    status_nxt.line_done  = line_done_nxt;
    status_nxt.cr_seen    = cr_seen_nxt;
    status_nxt.char_count = char_count_nxt;
    buf_wr.we             = item_acc && store_byte;
    buf_wr.addr           = char_count_r[crlf_pkg::ADDR_W-1:0];
    buf_wr.data           = rx_byte;
  end

`ifndef SYNTHESIS
  // A stored character always lands inside the buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.we |-> !buf_full)
    else $error("buffer write while full");

  // The count never passes the buffer depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= crlf_pkg::CNT_W'(crlf_pkg::BUF_DEPTH))
    else $error("character count beyond buffer depth");

  // A complete line has no CR waiting for its LF.
  assert property (@(posedge clk) disable iff (!rst_n)
    line_done_r |-> !cr_seen_r)
    else $error("line complete with CR still pending");
`endif

endmodule

// ===== tb/crlf_line_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_receiver_top_tb: self-checking bench for the CR LF line receiver
// Streams byte, clear, read and spare items into the block while a local
// line tracker predicts status and buffer contents for every transfer, then
// compares each result transfer field by field under random stalls on both
// sides of the block.
// ----------------------------------------------------------------------------
module crlf_line_receiver_top_tb;

  // Item kind that the block leaves unused.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Receiver stall styles.
  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_EVERY4 = 2;
  localparam int STALL_HEAVY  = 3;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx;
    logic [7:0] idx;
  } line_item_t;

  typedef struct packed {
    logic       ready;
    logic       pending;
    logic [8:0] length;
    logic [7:0] entry;
  } line_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] rx_byte, [15:8] read_index
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] line_ready, [1] cr_pending,
                                // [10:2] line_length, [18:11] entry_data

  line_item_t   pending_items[$];
  line_status_t expected_status[$];

  // Generator-side line tracker: decides which buffer entries may be read.
  logic [8:0] gen_count = '0;
  logic       gen_cr = 1'b0;
  logic       gen_done = 1'b0;
  int         gen_high = 0;
  int         items_queued = 0;

  // Checker-side line tracker and buffer copy.
  logic [8:0] chk_count = '0;
  logic       chk_cr = 1'b0;
  logic       chk_done = 1'b0;
  logic [7:0] line_copy [crlf_pkg::BUF_DEPTH];

  int mismatches = 0;
  int results_seen = 0;
  int reads_checked = 0;
  int lines_completed = 0;
  int overflows = 0;
  int cycles = 0;

  line_item_t driven_item;
  int         burst_left = 1;
  int         gap_left = 0;
  int         stall_style = STALL_NONE;

  crlf_line_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advances the line control state by one item. Returns 1 when the byte is
  // stored at the count held before the call.
  function automatic logic advance_line(input logic [1:0] mode, input logic [7:0] rx,
                                        inout logic [8:0] count, inout logic cr,
                                        inout logic done);
    logic stored;
    stored = 1'b0;
    if (mode == crlf_pkg::MODE_BYTE) begin
      if (!done) begin
        if (cr) begin
          // An LF completes the line; anything else throws it away.
          if (rx == crlf_pkg::CHAR_LF) begin
            done = 1'b1;
          end else begin
            count = '0;
          end
          cr = 1'b0;
        end else if (rx == crlf_pkg::CHAR_CR) begin
          cr = 1'b1;
        end else if (count >= crlf_pkg::BUF_DEPTH) begin
          count = '0;
          cr = 1'b0;
        end else begin
          stored = 1'b1;
          count = count + 9'd1;
        end
      end
    end else if (mode == crlf_pkg::MODE_CLEAR) begin
      count = '0;
      cr = 1'b0;
      done = 1'b0;
    end
    return stored;
  endfunction

  task automatic report_mismatch(input string field, input logic [8:0] got,
                                 input logic [8:0] want);
    $display("Mismatch at cycle %0d: %s is %0h, expected %0h", cycles, field, got, want);
    mismatches++;
  endtask

  // Queues one item and keeps the generator tracker in step with it.
  task automatic add_item(input logic [1:0] mode, input logic [7:0] rx, input logic [7:0] idx);
    line_item_t item;
    logic       unused;
    item.mode = mode;
    item.rx = rx;
    item.idx = idx;
    pending_items.push_back(item);
    unused = advance_line(mode, rx, gen_count, gen_cr, gen_done);
    if (gen_count > gen_high) gen_high = gen_count;
    items_queued++;
  endtask

  // Reads only entries that some earlier byte has written.
  task automatic add_read();
    if (gen_high == 0) begin
      add_item(crlf_pkg::MODE_BYTE, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    end else begin
      add_item(crlf_pkg::MODE_READ, 8'($urandom_range(255, 0)),
               8'($urandom_range(gen_high - 1, 0)));
    end
  endtask

  task automatic add_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == crlf_pkg::CHAR_CR);
    add_item(crlf_pkg::MODE_BYTE, b, 8'($urandom_range(255, 0)));
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(crlf_pkg::MODE_BYTE, b, 8'($urandom_range(255, 0)));
  endtask

  task automatic add_clear();
    add_item(crlf_pkg::MODE_CLEAR, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
  endtask

  // One line with random content, mostly properly terminated.
  task automatic add_line_sequence();
    int len;
    int ending;
    len = ($urandom_range(15, 0) == 0) ? $urandom_range(257, 0) : $urandom_range(12, 0);
    for (int i = 0; i < len; i++) add_text_byte();
    ending = $urandom_range(9, 0);
    if (ending <= 6) begin
      add_byte(crlf_pkg::CHAR_CR);
      add_byte(crlf_pkg::CHAR_LF);
    end else if (ending == 7) begin
      add_byte(crlf_pkg::CHAR_CR);
      add_text_byte();
    end else if (ending == 8) begin
      add_byte(crlf_pkg::CHAR_CR);
      add_byte(crlf_pkg::CHAR_CR);
    end
    repeat ($urandom_range(4, 0)) add_read();
    repeat ($urandom_range(2, 0)) add_byte(8'($urandom_range(255, 0)));
    if ($urandom_range(3, 0) != 0) add_clear();
  endtask

  task automatic add_noise();
    logic [1:0] mode;
    mode = 2'($urandom_range(3, 0));
    if (mode == crlf_pkg::MODE_READ) begin
      add_read();
    end else begin
      add_item(mode, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_status.size() != 0);
  endtask

  // Works out the result of an accepted input transfer.
  task automatic predict_item(input line_item_t item);
    line_status_t want;
    logic [7:0]   slot;
    logic         was_done;
    want.entry = '0;
    if (item.mode == crlf_pkg::MODE_READ) begin
      want.entry = line_copy[item.idx];
      reads_checked++;
    end
    slot = chk_count[7:0];
    was_done = chk_done;
    if (item.mode == crlf_pkg::MODE_BYTE && !chk_cr && !chk_done &&
        item.rx != crlf_pkg::CHAR_CR && chk_count >= crlf_pkg::BUF_DEPTH) overflows++;
    if (advance_line(item.mode, item.rx, chk_count, chk_cr, chk_done)) begin
      line_copy[slot] = item.rx;
    end
    if (chk_done && !was_done) lines_completed++;
    want.ready = chk_done;
    want.pending = chk_cr;
    want.length = chk_count;
    expected_status.push_back(want);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(driven_item);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          driven_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {driven_item.idx, driven_item.rx};
          in_tuser <= driven_item.mode;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall pattern whose style is redrawn at random at regular
  // intervals, plus the result check and the run limit.
  always @(posedge clk) begin
    line_status_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d results outstanding",
               CYCLE_LIMIT, expected_status.size());
      $display("crlf_line_receiver_top_tb NOT OK");
      $finish;
    end else begin
      if (cycles % 128 == 0) stall_style = $urandom_range(3, 0);
      case (stall_style)
        STALL_NONE:   out_tready <= 1'b1;
        STALL_RANDOM: out_tready <= 1'($urandom_range(1, 0));
        STALL_EVERY4: out_tready <= (cycles % 4) != 0;
        default:      out_tready <= ($urandom_range(7, 0) == 0);
      endcase
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected result", 9'(out_tdata[10:2]), '0);
        end else begin
          want = expected_status.pop_front();
          if (out_tdata[0] !== want.ready)
            report_mismatch("line_ready", 9'(out_tdata[0]), 9'(want.ready));
          if (out_tdata[1] !== want.pending)
            report_mismatch("cr_pending", 9'(out_tdata[1]), 9'(want.pending));
          if (out_tdata[10:2] !== want.length)
            report_mismatch("line_length", out_tdata[10:2], want.length);
          if (out_tdata[18:11] !== want.entry)
            report_mismatch("entry_data", 9'(out_tdata[18:11]), 9'(want.entry));
          if (out_tdata[23:19] !== 5'd0)
            report_mismatch("padding", 9'(out_tdata[23:19]), '0);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < crlf_pkg::BUF_DEPTH; i++) line_copy[i] = '0;

    // Directed: plain line, LF without CR, reads, ignored bytes after a
    // complete line, stale read, bad byte after CR, double CR, spare kind.
    add_clear();
    add_item(MODE_SPARE, 8'hff, 8'hff);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(crlf_pkg::CHAR_LF);
    add_byte(8'h7f);
    add_item(crlf_pkg::MODE_READ, 8'h00, 8'd0);
    add_item(crlf_pkg::MODE_READ, 8'hff, 8'd3);
    add_byte(crlf_pkg::CHAR_CR);
    add_byte(crlf_pkg::CHAR_LF);
    add_byte(8'h41);
    add_byte(crlf_pkg::CHAR_CR);
    add_item(crlf_pkg::MODE_READ, 8'h00, 8'd2);
    add_clear();
    add_item(crlf_pkg::MODE_READ, 8'h00, 8'd1);
    add_byte(8'h55);
    add_byte(crlf_pkg::CHAR_CR);
    add_byte(8'h41);
    add_byte(crlf_pkg::CHAR_CR);
    add_byte(crlf_pkg::CHAR_CR);
    add_byte(crlf_pkg::CHAR_CR);
    add_clear();
    add_item(MODE_SPARE, 8'h00, 8'h00);

    // Full buffer: one byte too many discards the line, then a full line
    // with CR LF and reads across the whole buffer.
    repeat (crlf_pkg::BUF_DEPTH) add_text_byte();
    add_byte(8'h5a);
    repeat (crlf_pkg::BUF_DEPTH) add_text_byte();
    add_byte(crlf_pkg::CHAR_CR);
    add_byte(crlf_pkg::CHAR_LF);
    add_item(crlf_pkg::MODE_READ, 8'h00, 8'd255);
    add_item(crlf_pkg::MODE_READ, 8'hff, 8'd128);
    repeat (6) add_read();
    add_byte(8'h20);
    add_clear();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Queue no further items until the block has answered everything so far.
    wait_for_drain();

    // Random part: mostly whole lines, some noise.
    for (int n = 0; items_queued < 600; n++) begin
      if ($urandom_range(9, 0) < 8) add_line_sequence();
      else add_noise();
      if (n == 2) wait_for_drain();
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d items, checked %0d results: %0d buffer reads, %0d completed lines,",
             items_queued, results_seen, reads_checked, lines_completed);
    $display("%0d discards on a full buffer, %0d mismatches", overflows, mismatches);
    if (mismatches == 0) begin
      $display("crlf_line_receiver_top_tb OK");
    end else begin
      $display("crlf_line_receiver_top_tb NOT OK");
    end
    $finish;
  end

endmodule
